// ===== rtl/prr_pkg.sv =====
// Shared types and codes for the priority round-robin task scheduler.
// No dependencies; imported by every module of the block.
package prr_pkg;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_START    = 2'd1,
    OP_TICK     = 2'd2,
    OP_NOP      = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_PICK,
    S_READ,
    S_DONE
  } seq_state_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_REJECTED = 2'd1;
  localparam logic [1:0] STATUS_DROPPED  = 2'd2;

  localparam logic [7:0] IDLE_QUANTUM = 8'd1;

  typedef struct packed {
    logic [7:0] pid;
    logic [7:0] quantum;
  } task_rec_t;

  typedef struct packed {
    logic [1:0] status;
    logic       switched;
    logic       running_valid;
    logic [7:0] running_pid;
    logic [2:0] running_niceness;
    logic [7:0] quantum_left;
    logic [7:0] assigned_pid;
  } result_t;

endpackage

// ===== rtl/prr_queue_mem.sv =====
// Task record store: one write port, one read port, registered read data.
// Depends on prr_pkg for the record type.
module prr_queue_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  prr_pkg::task_rec_t   wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output prr_pkg::task_rec_t   rd_data
);
  import prr_pkg::*;

  task_rec_t mem [DEPTH];
  task_rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/prr_seq.sv =====
// Scheduler sequencer: per-level ring pointers, running record, and the
// enqueue / pick / read steps against the record store. Depends on prr_pkg.
module prr_seq #(
  parameter int LEVELS      = 8,
  parameter int QUEUE_DEPTH = 8,
  parameter int AW          = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_opcode,
  input  logic [2:0]           in_niceness,
  input  logic [7:0]           in_quantum,
  output logic                 mem_wr_en,
  output logic [AW-1:0]        mem_wr_addr,
  output prr_pkg::task_rec_t   mem_wr_data,
  output logic                 mem_rd_en,
  output logic [AW-1:0]        mem_rd_addr,
  input  prr_pkg::task_rec_t   mem_rd_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output prr_pkg::result_t     res
);
  import prr_pkg::*;

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QW-1:0] LAST_IDX   = QW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
  localparam logic [LW-1:0] IDLE_LEVEL = LW'(LEVELS - 1);

  seq_state_t state_r, state_nxt;
  opcode_t    op_r;
  logic [2:0] nice_r;
  logic [7:0] quant_r;

  logic [QW-1:0] head_r  [LEVELS];
  logic [QW-1:0] tail_r  [LEVELS];
  logic [CW-1:0] count_r [LEVELS];

  logic          run_valid_r;
  logic [7:0]    run_pid_r;
  logic [LW-1:0] run_level_r;
  logic [7:0]    run_quant_r;
  logic [7:0]    qcnt_r;
  logic [7:0]    next_pid_r;
  logic [1:0]    status_r;
  logic          switched_r;
  logic [7:0]    assigned_r;

  logic          accept;
  logic          enq_in_range;
  logic          enq_ok;
  logic [LW-1:0] enq_lvl;
  task_rec_t     enq_rec;
  logic          pick_found;
  logic [LW-1:0] pick_lvl;

  function automatic logic [QW-1:0] next_idx(input logic [QW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + QW'(1);
  endfunction

  assign accept = in_valid && in_ready;

  // Enqueue target depends on which item is in flight.
  always_comb begin
    enq_in_range = 1'b1;
    enq_lvl      = run_level_r;
    enq_rec.pid  = next_pid_r;
    enq_rec.quantum = quant_r;
    unique case (op_r)
      OP_REGISTER: begin
        enq_in_range = (32'(nice_r) < LEVELS);
        enq_lvl      = LW'(nice_r);
      end
      OP_START: begin
        enq_lvl         = IDLE_LEVEL;
        enq_rec.quantum = IDLE_QUANTUM;
      end
      OP_TICK: begin
        enq_rec.pid     = run_pid_r;
        enq_rec.quantum = run_quant_r;
      end
      OP_NOP: begin
        enq_in_range = 1'b0;
      end
    endcase
    enq_ok = enq_in_range && (count_r[enq_lvl] != FULL_COUNT);
  end

  // The lowest-numbered nonempty level wins; the idle level is searched too.
  always_comb begin
    pick_found = 1'b0;
    pick_lvl   = '0;
    for (int n = LEVELS - 1; n >= 0; n--) begin
      if (count_r[n] != '0) begin
        pick_found = 1'b1;
        pick_lvl   = LW'(n);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          priority if (opcode_t'(in_opcode) == OP_REGISTER ||
                       opcode_t'(in_opcode) == OP_START) begin
            state_nxt = S_ENQ;
          end else if (opcode_t'(in_opcode) == OP_TICK && run_valid_r &&
                       qcnt_r == '0) begin
            state_nxt = S_ENQ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_ENQ: begin
        priority if (op_r == OP_TICK) begin
          state_nxt = S_PICK;
        end else if (op_r == OP_START && !run_valid_r) begin
          state_nxt = S_PICK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PICK:  state_nxt = pick_found ? S_READ : S_DONE;
      S_READ:  state_nxt = S_DONE;
      S_DONE:  state_nxt = res_ready ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready    = 1'b0;
    mem_wr_en   = 1'b0;
    mem_rd_en   = 1'b0;
    res_valid   = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready  = 1'b1;
      S_ENQ:   mem_wr_en = enq_ok;
      S_PICK:  mem_rd_en = pick_found;
      S_READ:  ;
      S_DONE:  res_valid = 1'b1;
      default: ;
    endcase
  end

  assign mem_wr_addr = {enq_lvl, tail_r[enq_lvl]};
  assign mem_wr_data = enq_rec;
  assign mem_rd_addr = {pick_lvl, head_r[pick_lvl]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= opcode_t'(in_opcode);
      nice_r  <= in_niceness;
      quant_r <= in_quantum;
    end
  end

  // The write of a requeued record lands before any read of it is issued,
  // so the store needs no forwarding path.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < LEVELS; n++) begin
        head_r[n]  <= '0;
        tail_r[n]  <= '0;
        count_r[n] <= '0;
      end
      run_valid_r <= 1'b0;
      run_pid_r   <= '0;
      run_level_r <= '0;
      run_quant_r <= '0;
      qcnt_r      <= '0;
      next_pid_r  <= '0;
      status_r    <= STATUS_OK;
      switched_r  <= 1'b0;
      assigned_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            status_r   <= STATUS_OK;
            switched_r <= 1'b0;
            assigned_r <= '0;
            if (opcode_t'(in_opcode) == OP_TICK && run_valid_r && qcnt_r != '0) begin
              qcnt_r <= qcnt_r - 8'd1;
            end
          end
        end
        S_ENQ: begin
          if (enq_ok) begin
            tail_r[enq_lvl]  <= next_idx(tail_r[enq_lvl]);
            count_r[enq_lvl] <= count_r[enq_lvl] + CW'(1);
            if (op_r != OP_TICK) begin
              assigned_r <= next_pid_r;
              next_pid_r <= next_pid_r + 8'd1;
            end
          end else begin
            status_r <= (op_r == OP_TICK) ? STATUS_DROPPED : STATUS_REJECTED;
          end
        end
        S_PICK: begin
          switched_r <= 1'b1;
          if (pick_found) begin
            head_r[pick_lvl]  <= next_idx(head_r[pick_lvl]);
            count_r[pick_lvl] <= count_r[pick_lvl] - CW'(1);
            run_level_r       <= pick_lvl;
          end else begin
            run_valid_r <= 1'b0;
            run_pid_r   <= '0;
            run_level_r <= '0;
            run_quant_r <= '0;
            qcnt_r      <= '0;
          end
        end
        S_READ: begin
          run_valid_r <= 1'b1;
          run_pid_r   <= mem_rd_data.pid;
          run_quant_r <= mem_rd_data.quantum;
          qcnt_r      <= mem_rd_data.quantum;
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    res.status           = status_r;
    res.switched         = switched_r;
    res.running_valid    = run_valid_r;
    res.running_pid      = run_valid_r ? run_pid_r : 8'd0;
    res.running_niceness = run_valid_r ? 3'(run_level_r) : 3'd0;
    res.quantum_left     = qcnt_r;
    res.assigned_pid     = assigned_r;
  end

endmodule

// ===== rtl/priority_round_robin_task_scheduler_top.sv =====
// Top level of the priority round-robin task scheduler: sequencer, record
// store and the result register. Depends on prr_pkg, prr_seq, prr_queue_mem.
//
//   channel  ports                                   handshake
//   input    in_opcode, in_niceness, in_quantum      in_valid / in_ready
//   result   out_status ... out_assigned_pid         out_valid / out_ready
//
// An item goes from idle straight to its result (tick that only counts down or
// finds nothing running, no-op), via the enqueue write (register, start with a
// task running), or, when it dispatches, via enqueue write, pick and store read,
// read data and result; the store's registered read adds the read-data step.
// Reset is synchronous, active low; it clears pointers, counts and the running
// record, the store itself needs no clearing. A held result stalls only the
// finishing step of the next item, which waits for the result register.
module priority_round_robin_task_scheduler_top #(
  parameter int LEVELS      = 8,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [2:0] in_niceness,
  input  logic [7:0] in_quantum,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic       out_switched,
  output logic       out_running_valid,
  output logic [7:0] out_running_pid,
  output logic [2:0] out_running_niceness,
  output logic [7:0] out_quantum_left,
  output logic [7:0] out_assigned_pid
);
  import prr_pkg::*;

  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int QW    = $clog2(QUEUE_DEPTH);
  localparam int AW    = LW + QW;
  localparam int DEPTH = 1 << AW;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  task_rec_t     mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  task_rec_t     mem_rd_data;
  logic          res_valid;
  logic          res_ready;
  result_t       res;

  logic          out_valid_r;
  result_t       out_res_r;

  prr_seq #(
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_niceness (in_niceness),
    .in_quantum  (in_quantum),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  prr_queue_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_queue_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Load a new beat when the register is empty or its beat leaves this cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_res_r.status;
  assign out_switched         = out_res_r.switched;
  assign out_running_valid    = out_res_r.running_valid;
  assign out_running_pid      = out_res_r.running_pid;
  assign out_running_niceness = out_res_r.running_niceness;
  assign out_quantum_left     = out_res_r.quantum_left;
  assign out_assigned_pid     = out_res_r.assigned_pid;

endmodule
